>>> rtl/core/lbfg_pkg.sv
// Shared types, widths and constants of the load based frequency governor.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lbfg_pkg;

  localparam int FREQ_W     = 22;
  localparam int PCT_W      = 7;
  localparam int TIME_W     = 48;
  localparam int IVL_W      = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Signed request width: holds current_freq plus a full up step and
  // current_freq minus the down step.
  localparam int REQ_W = FREQ_W + 2;

  // Shared divider geometry: the dividend covers 100 times a 48 bit interval.
  localparam int DIV_NUM_W = 55;
  localparam int DIV_DEN_W = TIME_W;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  localparam logic [FREQ_W-1:0] DOWN_STEP_KHZ   = FREQ_W'(256000);
  localparam logic [TIME_W-1:0] MIN_INTERVAL_US = TIME_W'(1000);

  localparam logic [FREQ_W-1:0] MIN_FREQ_RST      = FREQ_W'(0);
  localparam logic [FREQ_W-1:0] MAX_FREQ_RST      = FREQ_W'(4194303);
  localparam logic [FREQ_W-1:0] IDEAL_FREQ_RST    = FREQ_W'(998400);
  localparam logic [PCT_W-1:0]  HIGH_LOAD_RST     = PCT_W'(54);
  localparam logic [PCT_W-1:0]  LOW_LOAD_RST      = PCT_W'(15);
  localparam logic [IVL_W-1:0]  UP_INTERVAL_RST   = IVL_W'(45000);
  localparam logic [IVL_W-1:0]  DOWN_INTERVAL_RST = IVL_W'(45000);
  localparam logic [FREQ_W-1:0] UP_STEP_RST       = FREQ_W'(256000);

  typedef enum logic [1:0] {
    DEC_IGNORED = 2'd0,
    DEC_HELD    = 2'd1,
    DEC_RAISED  = 2'd2,
    DEC_LOWERED = 2'd3
  } decision_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_FREQ      = 3'd0,
    REG_MAX_FREQ      = 3'd1,
    REG_IDEAL_FREQ    = 3'd2,
    REG_HIGH_LOAD     = 3'd3,
    REG_LOW_LOAD      = 3'd4,
    REG_UP_INTERVAL   = 3'd5,
    REG_DOWN_INTERVAL = 3'd6,
    REG_UP_STEP       = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INTERVAL,
    S_SCALE,
    S_DIV_LOAD,
    S_ELAPSED,
    S_DECIDE,
    S_STEP,
    S_DIV_PROP,
    S_CLAMP,
    S_RESOLVE,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/lbfg_in_if.sv
// Sample request channel of the governor: valid, ready and the sample fields.
// Depends on lbfg_pkg for the field widths.
`default_nettype none

interface lbfg_in_if import lbfg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   idle_total_us;
  logic [TIME_W-1:0]   wall_total_us;
  logic [FREQ_W-1:0]   current_freq;
  logic                many_runnable;

  modport source (output valid, idle_total_us, wall_total_us, current_freq, many_runnable,
                  input ready);
  modport sink   (input valid, idle_total_us, wall_total_us, current_freq, many_runnable,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/lbfg_out_if.sv
// Result request channel of the governor: valid, ready and the decision fields.
// Depends on lbfg_pkg for the field widths.
`default_nettype none

interface lbfg_out_if import lbfg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  target_freq;
  logic [PCT_W-1:0]   load_pct;
  logic [1:0]         decision;

  modport source (output valid, target_freq, load_pct, decision, input ready);
  modport sink   (input valid, target_freq, load_pct, decision, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lbfg_div.sv
// Bit-serial restoring divider shared by the load and proportional step paths.
// Depends on lbfg_pkg for its widths; one quotient bit per cycle.
`default_nettype none

module lbfg_div import lbfg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] dividend,
  input  logic [DIV_DEN_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  logic                 active;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_NUM_W-1:0] shreg;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem, shreg[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      count  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (active) begin
      count <= count - DIV_CNT_W'(1);
      if (count == DIV_CNT_W'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      den   <= divisor;
      rem   <= '0;
    end else if (active) begin
      rem   <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      shreg <= {shreg[DIV_NUM_W-2:0], fits};
    end
  end

  assign quotient = shreg;

endmodule

`default_nettype wire

>>> rtl/core/load_based_frequency_governor.sv
// Load based frequency governor: one decision per sample request.
// An ignored sample yields its result without any division, and so does a zero load
// decision; any other waits for the shared divider, which divides again on the
// proportional path when the down step is zero.
// One sample at a time; the next is taken once the result has entered the output register.
// Reset (synchronous, rst high) restores the register defaults and clears the baseline.
`default_nettype none

module load_based_frequency_governor import lbfg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lbfg_in_if.sink               inbound,
  lbfg_out_if.source            outbound
);

  // Configuration registers.
  logic [FREQ_W-1:0] min_freq;
  logic [FREQ_W-1:0] max_freq;
  logic [FREQ_W-1:0] ideal_freq;
  logic [PCT_W-1:0]  high_load_pct;
  logic [PCT_W-1:0]  low_load_pct;
  logic [IVL_W-1:0]  up_interval_us;
  logic [IVL_W-1:0]  down_interval_us;
  logic [FREQ_W-1:0] up_step_khz;

  // Baseline kept between samples.
  logic              primed;
  logic [TIME_W-1:0] last_idle;
  logic [TIME_W-1:0] last_wall;
  logic [TIME_W-1:0] last_change;

  // The sample being worked on.
  logic [TIME_W-1:0] s_idle;
  logic [TIME_W-1:0] s_wall;
  logic [FREQ_W-1:0] s_cur;
  logic              s_many;

  // Intermediate values of the sequence.
  logic [TIME_W-1:0] di;
  logic [TIME_W-1:0] dw;
  logic [TIME_W-1:0] busy;
  logic [TIME_W-1:0] elapsed;
  logic              go_up;
  logic              go_down;
  logic signed [REQ_W-1:0] req;

  // Result under construction and the output register.
  logic [FREQ_W-1:0] res_freq;
  logic [PCT_W-1:0]  res_load;
  decision_t         res_dec;
  logic              out_valid;
  logic [FREQ_W-1:0] out_freq;
  logic [PCT_W-1:0]  out_load;
  decision_t         out_dec;

  state_t state;
  state_t state_next;

  // Shared divider hookup.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_dividend;
  logic [DIV_DEN_W-1:0] div_divisor;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quot;

  logic                 in_take;
  logic                 out_load_en;
  logic                 prop_path;
  logic [DIV_NUM_W-1:0] busy_ext;
  logic [DIV_NUM_W-1:0] busy_x100;
  logic [FREQ_W+PCT_W-1:0] prop_prod;
  logic signed [REQ_W-1:0] cur_s;
  logic signed [REQ_W-1:0] min_s;
  logic signed [REQ_W-1:0] max_s;

  lbfg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign cur_s = $signed({2'b00, s_cur});
  assign min_s = $signed({2'b00, min_freq});
  assign max_s = $signed({2'b00, max_freq});

  // 100 times the busy time, built from three shifted copies (64 + 32 + 4).
  assign busy_ext  = DIV_NUM_W'(busy);
  assign busy_x100 = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
  assign prop_prod = s_cur * res_load;

  // The proportional step is used only when a lowering request sits at or below
  // the ideal frequency and the fixed down step is zero.
  assign prop_path = go_down && !(s_cur > ideal_freq) && (DOWN_STEP_KHZ == '0);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq         <= MIN_FREQ_RST;
      max_freq         <= MAX_FREQ_RST;
      ideal_freq       <= IDEAL_FREQ_RST;
      high_load_pct    <= HIGH_LOAD_RST;
      low_load_pct     <= LOW_LOAD_RST;
      up_interval_us   <= UP_INTERVAL_RST;
      down_interval_us <= DOWN_INTERVAL_RST;
      up_step_khz      <= UP_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_FREQ:      min_freq         <= cfg_data[FREQ_W-1:0];
        REG_MAX_FREQ:      max_freq         <= cfg_data[FREQ_W-1:0];
        REG_IDEAL_FREQ:    ideal_freq       <= cfg_data[FREQ_W-1:0];
        REG_HIGH_LOAD:     high_load_pct    <= cfg_data[PCT_W-1:0];
        REG_LOW_LOAD:      low_load_pct     <= cfg_data[PCT_W-1:0];
        REG_UP_INTERVAL:   up_interval_us   <= cfg_data[IVL_W-1:0];
        REG_DOWN_INTERVAL: down_interval_us <= cfg_data[IVL_W-1:0];
        REG_UP_STEP:       up_step_khz      <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (inbound.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        // The first sample only primes the baseline; a repeated wall reading
        // is dropped without touching it.
        if (!primed || s_wall == last_wall) state_next = S_FINISH;
        else state_next = S_INTERVAL;
      end
      S_INTERVAL: begin
        // A short interval is ignored; idle beyond wall time means zero load
        // and needs no division.
        if (dw < MIN_INTERVAL_US) state_next = S_FINISH;
        else if (di > dw) state_next = S_ELAPSED;
        else state_next = S_SCALE;
      end
      S_SCALE: state_next = S_DIV_LOAD;
      S_DIV_LOAD: begin
        if (div_done) state_next = S_ELAPSED;
      end
      S_ELAPSED: state_next = S_DECIDE;
      S_DECIDE:  state_next = S_STEP;
      S_STEP: begin
        if (prop_path) state_next = S_DIV_PROP;
        else state_next = S_CLAMP;
      end
      S_DIV_PROP: begin
        if (div_done) state_next = S_CLAMP;
      end
      S_CLAMP:   state_next = S_RESOLVE;
      S_RESOLVE: state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || outbound.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_take      = 1'b0;
    out_load_en  = 1'b0;
    div_start    = 1'b0;
    div_dividend = busy_x100;
    div_divisor  = dw;
    unique case (state)
      S_IDLE: in_take = inbound.valid;
      S_SCALE: div_start = 1'b1;
      S_STEP: begin
        div_start    = prop_path;
        div_dividend = DIV_NUM_W'(prop_prod);
        div_divisor  = DIV_DEN_W'(high_load_pct);
      end
      S_FINISH: out_load_en = !out_valid || outbound.ready;
      default: ;
    endcase
  end

  assign inbound.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Baseline and change time; these must start from zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      primed      <= 1'b0;
      last_idle   <= '0;
      last_wall   <= '0;
      last_change <= '0;
    end else begin
      if (state == S_CHECK) begin
        if (!primed) begin
          primed    <= 1'b1;
          last_idle <= s_idle;
          last_wall <= s_wall;
        end else if (s_wall != last_wall) begin
          last_idle <= s_idle;
          last_wall <= s_wall;
        end
      end
      if (state == S_RESOLVE && req != cur_s) last_change <= s_wall;
    end
  end

  // Datapath of the sequence.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_take) begin
          s_idle <= inbound.idle_total_us;
          s_wall <= inbound.wall_total_us;
          s_cur  <= inbound.current_freq;
          s_many <= inbound.many_runnable;
        end
      end
      S_CHECK: begin
        res_freq <= s_cur;
        res_load <= '0;
        res_dec  <= DEC_IGNORED;
        di       <= s_idle - last_idle;
        dw       <= s_wall - last_wall;
      end
      S_INTERVAL: begin
        if (!(dw < MIN_INTERVAL_US)) res_dec <= DEC_HELD;
        busy <= dw - di;
      end
      S_DIV_LOAD: begin
        if (div_done) res_load <= div_quot[PCT_W-1:0];
      end
      S_ELAPSED: begin
        elapsed <= s_wall - last_change;
      end
      S_DECIDE: begin
        // High load, or no idle time at all, leaves the lowering test out.
        if (res_load > high_load_pct || di == '0) begin
          go_up   <= (s_cur < max_freq) &&
                     (s_cur < ideal_freq || di == '0 ||
                      elapsed >= TIME_W'(up_interval_us));
          go_down <= 1'b0;
        end else begin
          go_up   <= 1'b0;
          go_down <= (res_load < low_load_pct) && (s_cur > min_freq) &&
                     (s_cur > ideal_freq || elapsed >= TIME_W'(down_interval_us));
        end
      end
      S_STEP: begin
        // Without a raise or a lower the request stays at the current frequency;
        // the proportional path overwrites it once its quotient is in.
        if (go_up && s_many) begin
          if (s_cur < ideal_freq) req <= $signed({2'b00, ideal_freq});
          else if (up_step_khz != '0) req <= cur_s + $signed({2'b00, up_step_khz});
          else req <= max_s;
        end else if (go_down && s_cur > ideal_freq) begin
          req <= $signed({2'b00, ideal_freq});
        end else if (go_down && DOWN_STEP_KHZ != '0) begin
          req <= cur_s - $signed({2'b00, DOWN_STEP_KHZ});
        end else begin
          req <= cur_s;
        end
      end
      S_DIV_PROP: begin
        // A quotient above the current frequency (including division by a
        // zero threshold, which gives all ones) becomes one kHz below it.
        if (div_done) begin
          if (div_quot > DIV_NUM_W'(s_cur)) req <= cur_s - REQ_W'(1);
          else req <= $signed({2'b00, div_quot[FREQ_W-1:0]});
        end
      end
      S_CLAMP: begin
        // Only a request that differs from the current frequency is clamped;
        // the maximum is checked first.
        if (req != cur_s) begin
          if (req > max_s) req <= max_s;
          else if (req < min_s) req <= min_s;
        end
      end
      S_RESOLVE: begin
        if (req != cur_s) begin
          res_freq <= req[FREQ_W-1:0];
          res_dec  <= (req > cur_s) ? DEC_RAISED : DEC_LOWERED;
        end
      end
      default: ;
    endcase
  end

  // Output register: the next sample may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_en) begin
      out_valid <= 1'b1;
    end else if (outbound.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load_en) begin
      out_freq <= res_freq;
      out_load <= res_load;
      out_dec  <= res_dec;
    end
  end

  assign outbound.valid       = out_valid;
  assign outbound.target_freq = out_freq;
  assign outbound.load_pct    = out_load;
  assign outbound.decision    = out_dec;

endmodule

`default_nettype wire

>>> rtl/core/lbfg_checker.sv
// Port level checks of the governor, bound to the top level.
// Depends on lbfg_pkg for widths and decision codes.
`default_nettype none

module lbfg_checker import lbfg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] target_freq,
  input logic [PCT_W-1:0]  load_pct,
  input logic [1:0]        decision
);

  // A taken sample keeps the block busy for at least the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample request taken while the previous one is still in work");

  // Load is a percentage.
  a_load_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> load_pct <= PCT_W'(100))
    else $error("load above 100 percent");

  // An ignored sample reports no load.
  a_ignored_no_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && decision == DEC_IGNORED |-> load_pct == '0)
    else $error("ignored sample carries a load value");

  // A waiting result stays valid and keeps its frequency and decision.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_freq) && $stable(decision))
    else $error("pending result request changed");

endmodule

bind load_based_frequency_governor lbfg_checker u_lbfg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (inbound.valid),
  .in_ready    (inbound.ready),
  .out_valid   (outbound.valid),
  .out_ready   (outbound.ready),
  .target_freq (outbound.target_freq),
  .load_pct    (outbound.load_pct),
  .decision    (outbound.decision)
);

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the load based frequency governor: drives sample requests,
// predicts every decision in a behavioral model and checks each result request in order.
// Depends on lbfg_pkg, lbfg_in_if, lbfg_out_if and the load_based_frequency_governor RTL.

module testbench;
  import lbfg_pkg::*;

  // One expected result request, in the widths of the result channel.
  typedef struct {
    logic [FREQ_W-1:0] target_freq;
    logic [PCT_W-1:0]  load_pct;
    decision_t         decision;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbfg_in_if  samples_if ();
  lbfg_out_if verdicts_if ();

  load_based_frequency_governor u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .inbound   (samples_if),
    .outbound  (verdicts_if)
  );

  // The bench's own copy of the tunables, kept in step with every register write.
  logic [FREQ_W-1:0] gov_min;
  logic [FREQ_W-1:0] gov_max;
  logic [FREQ_W-1:0] gov_ideal;
  logic [PCT_W-1:0]  gov_high;
  logic [PCT_W-1:0]  gov_low;
  logic [IVL_W-1:0]  gov_up_ivl;
  logic [IVL_W-1:0]  gov_down_ivl;
  logic [FREQ_W-1:0] gov_up_step;

  // The bench's own copy of the baseline that the block keeps between samples.
  logic [TIME_W-1:0] base_idle;
  logic [TIME_W-1:0] base_wall;
  logic [TIME_W-1:0] change_wall;
  logic              primed;

  // Running cumulative readings of the simulated core, and the frequency it runs at.
  // The core follows the governor's requests, which closes the loop and lets the
  // random traffic walk through the raise and lower paths instead of sitting still.
  logic [TIME_W-1:0] stream_idle;
  logic [TIME_W-1:0] stream_wall;
  logic [FREQ_W-1:0] core_freq;

  verdict_t pending_verdicts[$];
  int       mismatches;
  int       verdict_stall;
  logic     verdict_hold;
  logic     jitter_on;

  // 8 ns clock.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Behavioral prediction of one sample. It updates the baseline exactly as the block
  // must, so it is called once per accepted sample request, in acceptance order.
  function automatic verdict_t govern_sample(input logic [TIME_W-1:0] idle,
                                             input logic [TIME_W-1:0] wall,
                                             input logic [FREQ_W-1:0] cur,
                                             input logic              many);
    logic [TIME_W-1:0] di;
    logic [TIME_W-1:0] dw;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       load;
    logic [63:0]       quot;
    longint            req;
    longint            oldf;
    int                dir;
    verdict_t          v;
    v.target_freq = cur;
    v.load_pct    = '0;
    v.decision    = DEC_IGNORED;
    // The very first sample only establishes the baseline.
    if (!primed) begin
      primed    = 1'b1;
      base_idle = idle;
      base_wall = wall;
      return v;
    end
    // A repeated wall reading leaves the baseline untouched.
    if (wall == base_wall) return v;
    di        = idle - base_idle;
    dw        = wall - base_wall;
    base_idle = idle;
    base_wall = wall;
    // Too short an interval moves the baseline but decides nothing.
    if (dw < MIN_INTERVAL_US) return v;

    load    = (di > dw) ? 64'd0 : (64'd100 * (dw - di)) / dw;
    elapsed = wall - change_wall;
    dir     = 0;
    if (load > gov_high || di == '0) begin
      if (cur < gov_max && (cur < gov_ideal || di == '0 || elapsed >= gov_up_ivl)) dir = 1;
    end else if (load < gov_low && cur > gov_min &&
                 (cur > gov_ideal || elapsed >= gov_down_ivl)) begin
      dir = -1;
    end

    oldf = longint'(cur);
    req  = oldf;
    if (dir > 0 && many) begin
      if (cur < gov_ideal) req = longint'(gov_ideal);
      else if (gov_up_step != '0) req = oldf + longint'(gov_up_step);
      else req = longint'(gov_max);
    end else if (dir < 0) begin
      if (cur > gov_ideal) begin
        req = longint'(gov_ideal);
      end else if (DOWN_STEP_KHZ != '0) begin
        req = oldf - longint'(DOWN_STEP_KHZ);
      end else begin
        // Proportional fallback; a zero threshold saturates the quotient.
        if (gov_high == '0) quot = '1;
        else quot = (64'(cur) * load) / 64'(gov_high);
        req = (quot > 64'(cur)) ? oldf - 1 : longint'(quot);
      end
    end

    v.decision = DEC_HELD;
    if (req != oldf) begin
      // Max is tested first, which settles the case of min above max.
      if (req > longint'(gov_max)) req = longint'(gov_max);
      else if (req < longint'(gov_min)) req = longint'(gov_min);
      if (req != oldf) begin
        v.decision  = (req > oldf) ? DEC_RAISED : DEC_LOWERED;
        change_wall = wall;
      end
    end
    v.target_freq = req[FREQ_W-1:0];
    v.load_pct    = load[PCT_W-1:0];
    return v;
  endfunction

  // Offer one sample request, wait for it to be taken, then record its prediction.
  // Valid stays high into the next call, so back-to-back requests need no gap.
  task automatic send_sample(input logic [TIME_W-1:0] idle,
                             input logic [TIME_W-1:0] wall,
                             input logic [FREQ_W-1:0] cur,
                             input logic              many);
    int       gap;
    verdict_t v;
    gap = jitter_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      samples_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_if.idle_total_us = idle;
    samples_if.wall_total_us = wall;
    samples_if.current_freq  = cur;
    samples_if.many_runnable = many;
    samples_if.valid         = 1'b1;
    do @(posedge clk); while (!samples_if.ready);
    v = govern_sample(idle, wall, cur, many);
    pending_verdicts.push_back(v);
    stream_idle = idle;
    stream_wall = wall;
    core_freq   = v.target_freq;
  endtask

  // Advance the running readings by the given amounts and send the sample.
  task automatic step_sample(input logic [TIME_W-1:0] d_wall,
                             input logic [TIME_W-1:0] d_idle,
                             input logic [FREQ_W-1:0] cur,
                             input logic              many);
    send_sample(stream_idle + d_idle, stream_wall + d_wall, cur, many);
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic drain_requests();
    @(negedge clk);
    samples_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MIN_FREQ:      gov_min      = value[FREQ_W-1:0];
      REG_MAX_FREQ:      gov_max      = value[FREQ_W-1:0];
      REG_IDEAL_FREQ:    gov_ideal    = value[FREQ_W-1:0];
      REG_HIGH_LOAD:     gov_high     = value[PCT_W-1:0];
      REG_LOW_LOAD:      gov_low      = value[PCT_W-1:0];
      REG_UP_INTERVAL:   gov_up_ivl   = value[IVL_W-1:0];
      REG_DOWN_INTERVAL: gov_down_ivl = value[IVL_W-1:0];
      REG_UP_STEP:       gov_up_step  = value[FREQ_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every tunable once the block has gone quiet. Every sample yields a
  // result, so after the last one and a short settle the block is known idle.
  task automatic program_registers(input int unsigned mn, input int unsigned mx,
                                   input int unsigned ideal, input int unsigned hi,
                                   input int unsigned lo, input int unsigned up_ivl,
                                   input int unsigned down_ivl, input int unsigned up_step);
    drain_requests();
    repeat (8) @(posedge clk);
    write_reg(REG_MIN_FREQ,      CFG_DATA_W'(mn));
    write_reg(REG_MAX_FREQ,      CFG_DATA_W'(mx));
    write_reg(REG_IDEAL_FREQ,    CFG_DATA_W'(ideal));
    write_reg(REG_HIGH_LOAD,     CFG_DATA_W'(hi));
    write_reg(REG_LOW_LOAD,      CFG_DATA_W'(lo));
    write_reg(REG_UP_INTERVAL,   CFG_DATA_W'(up_ivl));
    write_reg(REG_DOWN_INTERVAL, CFG_DATA_W'(down_ivl));
    write_reg(REG_UP_STEP,       CFG_DATA_W'(up_step));
  endtask

  // Random traffic. Most samples are a plausible next reading of the same core
  // (interval around the rate limits, idle a random share of it); some are short
  // or repeated intervals, idle beyond the interval, and wholly random readings that
  // wrap the 48 bit counters and exercise every bit of the fields.
  task automatic random_samples(input int count);
    logic [TIME_W-1:0] d_wall;
    logic [TIME_W-1:0] d_idle;
    logic [FREQ_W-1:0] freq;
    logic [63:0]       r;
    int                pick;
    for (int n = 0; n < count; n++) begin
      // Idling is switched off for some stretches of 100 requests.
      if (n % 100 == 0) jitter_on = ($urandom_range(0, 3) != 0);

      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        d_wall = TIME_W'($urandom_range(1000, 120000));
      end else if (pick < 82) begin
        d_wall = TIME_W'($urandom_range(0, 1200));
      end else if (pick < 92) begin
        d_wall = TIME_W'($urandom_range(120000, 32'h7fff_ffff));
      end else begin
        r      = {$urandom, $urandom};
        d_wall = r[TIME_W-1:0];
      end

      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        d_idle = '0;
      end else if (pick < 25) begin
        d_idle = d_wall;
      end else if (pick < 32) begin
        d_idle = d_wall + TIME_W'($urandom_range(1, 5000));
      end else if (pick < 40) begin
        r      = {$urandom, $urandom};
        d_idle = r[TIME_W-1:0];
      end else begin
        d_idle = TIME_W'((64'(d_wall) * 64'($urandom_range(0, 100))) / 64'd100);
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        freq = core_freq;
      end else if (pick < 85) begin
        freq = FREQ_W'($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0:       freq = gov_min;
          1:       freq = gov_max;
          2:       freq = gov_ideal;
          3:       freq = gov_min + 1'b1;
          4:       freq = gov_max - 1'b1;
          default: freq = gov_ideal + 1'b1;
        endcase
      end

      step_sample(d_wall, d_idle, freq, $urandom_range(0, 3) != 0);
    end
  endtask

  // Directed walk through the corner cases under the reset tunables
  // (min 0, max all ones, ideal 998400, thresholds 54 and 15, intervals 45000).
  task automatic test_special_cases();
    jitter_on = 1'b1;
    // First sample after reset is ignored and only sets the baseline.
    send_sample(48'h0000_1234_5678, 48'h0001_0000_0000, 22'd500000, 1'b1);
    // Repeated wall reading is ignored and stores nothing.
    step_sample(48'd0, 48'd5, 22'd500000, 1'b1);
    // An interval one short of the minimum is ignored but moves the baseline.
    step_sample(48'd999, 48'd100, 22'd500000, 1'b1);
    // Exactly the minimum interval with no idle: full load, jump to the ideal.
    step_sample(48'd1000, 48'd0, 22'd500000, 1'b1);
    // No idle at the ideal, but only one task runnable: held.
    step_sample(48'd50000, 48'd0, 22'd998400, 1'b0);
    // Same with many runnable: a full up step, the rate limit bypassed.
    step_sample(48'd50000, 48'd0, 22'd998400, 1'b1);
    // High load at the maximum cannot rise.
    step_sample(48'd20000, 48'd2000, 22'd4194303, 1'b1);
    // Idle longer than the interval reads as zero load: drop to the ideal.
    step_sample(48'd20000, 48'd25000, 22'd3000000, 1'b1);
    // Low load at the ideal inside the down interval: held.
    step_sample(48'd10000, 48'd9500, 22'd998400, 1'b1);
    // Past the down interval: one down step.
    step_sample(48'd50000, 48'd49000, 22'd998400, 1'b1);
    // A down step below zero is lifted to the minimum.
    step_sample(48'd50000, 48'd49900, 22'd100000, 1'b1);
    // Already at the minimum: held.
    step_sample(48'd50000, 48'd49900, 22'd0, 1'b1);
    // An up step past the maximum is clamped to it.
    step_sample(48'd50000, 48'd1000, 22'd4194000, 1'b1);
    // Load exactly at the high threshold holds, one more percent raises.
    step_sample(48'd10000, 48'd4600, 22'd2000000, 1'b1);
    step_sample(48'd50000, 48'd22500, 22'd2000000, 1'b1);
    // Load exactly at the low threshold holds, one less percent lowers.
    step_sample(48'd50000, 48'd42500, 22'd998400, 1'b1);
    step_sample(48'd50000, 48'd43000, 22'd998400, 1'b1);
    // Both counters near the top, then wrapping through zero.
    send_sample(48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_FF00, 22'd2000000, 1'b1);
    step_sample(48'd1024, 48'd1024, 22'd2000000, 1'b1);
    step_sample(48'd60000, 48'd30000, 22'd4194303, 1'b0);
    drain_requests();
  endtask

  task automatic test_default_registers();
    random_samples(300);
    drain_requests();
  endtask

  // Plausible tunings: ordered limits, ideal between them, thresholds well apart.
  task automatic test_tuned_registers();
    int unsigned mn;
    int unsigned mx;
    int unsigned hi;
    for (int k = 0; k < 2; k++) begin
      mn = $urandom_range(0, 1500000);
      mx = $urandom_range(mn + 100000, 4194303);
      hi = $urandom_range(40, 95);
      program_registers(mn, mx, $urandom_range(mn, mx), hi, $urandom_range(1, hi - 10),
                        $urandom_range(0, 150000), $urandom_range(0, 150000),
                        ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 600000));
      random_samples(250);
    end
  endtask

  // Random tunings over wide register ranges, unordered limits included.
  task automatic test_random_registers();
    for (int k = 0; k < 2; k++) begin
      program_registers($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                        $urandom_range(0, 4194303), $urandom_range(1, 100),
                        $urandom_range(1, 99), $urandom_range(0, 100000000),
                        $urandom_range(0, 100000000), $urandom_range(0, 4194303));
      random_samples(200);
    end
  endtask

  // Low and high settings for every register. The low end has an ideal of zero and a zero up
  // step, so every raise jumps straight to the maximum; the high end puts the
  // minimum above the maximum, so the clamp order decides.
  task automatic test_register_extremes();
    program_registers(0, 4194303, 0, 1, 1, 0, 0, 0);
    random_samples(220);
    program_registers(4000000, 3000000, 3500000, 100, 99, 100000000, 100000000, 4194303);
    random_samples(220);
  endtask

  // The result side refuses for a long stretch while samples keep coming, so the
  // block fills and has to stall its sample input.
  task automatic test_output_backpressure();
    program_registers(MIN_FREQ_RST, MAX_FREQ_RST, IDEAL_FREQ_RST, HIGH_LOAD_RST,
                      LOW_LOAD_RST, UP_INTERVAL_RST, DOWN_INTERVAL_RST, UP_STEP_RST);
    fork
      begin
        verdict_hold = 1'b1;
        repeat (700) @(negedge clk);
        verdict_hold = 1'b0;
      end
    join_none
    random_samples(12);
    drain_requests();
  endtask

  // The sender goes quiet until every result is back, then resumes mid-stream.
  task automatic test_sender_pause();
    random_samples(10);
    drain_requests();
    random_samples(10);
    drain_requests();
  endtask

  // Result side ready: low in reset, during a hold-off, and for the drawn stall
  // after each accepted result; high otherwise.
  always @(negedge clk) begin
    if (rst || verdict_hold) begin
      verdicts_if.ready = 1'b0;
    end else if (verdict_stall > 0) begin
      verdicts_if.ready = 1'b0;
      verdict_stall--;
    end else begin
      verdicts_if.ready = 1'b1;
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdicts_if.valid && verdicts_if.ready) begin
      verdict_stall = jitter_on ? $urandom_range(0, 3) : 0;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: freq %0d load %0d decision %0d",
                   verdicts_if.target_freq, verdicts_if.load_pct, verdicts_if.decision);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdicts_if.target_freq !== want.target_freq ||
            verdicts_if.load_pct !== want.load_pct ||
            verdicts_if.decision !== want.decision) begin
          mismatches++;
          if (mismatches <= 10)
            $display("wrong result: expected freq %0d load %0d decision %0d,",
                     want.target_freq, want.load_pct, want.decision,
                     " got freq %0d load %0d decision %0d",
                     verdicts_if.target_freq, verdicts_if.load_pct, verdicts_if.decision);
        end
      end
    end
  end

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = REG_MIN_FREQ;
    cfg_data                 = '0;
    samples_if.valid         = 1'b0;
    samples_if.idle_total_us = '0;
    samples_if.wall_total_us = '0;
    samples_if.current_freq  = '0;
    samples_if.many_runnable = 1'b0;
    verdicts_if.ready        = 1'b0;
    verdict_stall            = 0;
    verdict_hold             = 1'b0;
    jitter_on                = 1'b1;
    mismatches               = 0;

    gov_min      = MIN_FREQ_RST;
    gov_max      = MAX_FREQ_RST;
    gov_ideal    = IDEAL_FREQ_RST;
    gov_high     = HIGH_LOAD_RST;
    gov_low      = LOW_LOAD_RST;
    gov_up_ivl   = UP_INTERVAL_RST;
    gov_down_ivl = DOWN_INTERVAL_RST;
    gov_up_step  = UP_STEP_RST;
    base_idle    = '0;
    base_wall    = '0;
    change_wall  = '0;
    primed       = 1'b0;
    stream_idle  = '0;
    stream_wall  = '0;
    core_freq    = IDEAL_FREQ_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_cases();
    test_default_registers();
    test_tuned_registers();
    test_random_registers();
    test_register_extremes();
    test_output_backpressure();
    test_sender_pause();

    // Quiet tail long enough for a stray result from a slow decision to show up.
    drain_requests();
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("load_based_frequency_governor: match");
    end else begin
      $display("load_based_frequency_governor: mismatch");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("load_based_frequency_governor: mismatch");
    $finish;
  end

endmodule
